// ----- src/shelf_rect_packer_with_grow_defines.svh -----
// Assertion helpers shared by the packer modules.
// Each macro expects i_clk and i_rst_n to be visible at the point of use.
`ifndef SHELF_RECT_PACKER_WITH_GROW_DEFINES_SVH
`define SHELF_RECT_PACKER_WITH_GROW_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define SRP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SRP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/srp_pkg.sv -----
`default_nettype none

package srp_pkg;

    localparam int SIDE_W = 11;
    localparam int POS_W  = 11;
    localparam int DIM_W  = 10;
    localparam int SLOT_W = 8;
    localparam int CUR_W  = 12;

    localparam int GLYPHS = 256;
    localparam int CNT_W  = $clog2(GLYPHS + 1);
    localparam int IDX_W  = $clog2(GLYPHS);

    localparam logic [SIDE_W-1:0] INIT_SIDE = SIDE_W'(256);
    localparam logic [SIDE_W-1:0] MAX_SIDE  = SIDE_W'(1024);

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 3;

    // Commands from the controller, one step of work each
    typedef struct packed {
        logic accept;
        logic q_read;
        logic fit_new;
        logic rp_read;
        logic rp_fit;
        logic load_out;
    } t_dp_cmd;

    // Status back to the controller
    typedef struct packed {
        logic in_query;
        logic full;
        logic fit_grow;
        logic idx_last;
        logic count_zero;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- src/shelf_rect_packer_with_grow.sv -----
`default_nettype none
`include "shelf_rect_packer_with_grow_defines.svh"

// Shelf packer for glyph rectangles in a square atlas (side 256 after reset, up to 1024,
// store of 256 glyphs). A place transaction (tuser = 0) gives a width and height and gets back
// the glyph origin inside a cell of (w+2) x (h+2) pixels, clamped to the side, together with
// the next slot number; a query transaction (tuser = 1) returns the stored origin of a slot.
// A cell that fits neither the current shelf nor a new one doubles the side and repacks every
// stored glyph in slot order; at the maximum side it wraps to the origin and is flagged as
// overlapped. A place into a full store, or a query of a slot not yet placed, returns zeros
// with the rejected flag. One transaction is worked on at a time through a single fit unit.
// A query or a place without growth passes through one work state (the store read or the fit)
// before the done state loads the result register, while a place into a full store goes
// straight to the done state; the load waits there until the register is free. The next
// transaction is taken in the idle state that follows the load. Each doubling rereads and
// refits every glyph already stored, one store read and one fit per glyph, in slot order; a
// stored glyph that overflows during the repack doubles again and restarts the repack from the
// first slot. The result register lets the next transaction be accepted while a result waits
// downstream.
// No store clearing is needed after reset.
module shelf_rect_packer_with_grow
    import srp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [9:0] glyph_width, [19:10] glyph_height, [27:20] glyph_slot, [31:28] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [10:0] pos_x, [21:11] pos_y, [32:22] side_now, [40:33] slot_given, [47:41] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] grew, [1] overlapped, [2] rejected
    output logic [OUT_USER_W-1:0]      m_axis_tuser
);

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIDE_W-1:0] side_now;
    logic [SLOT_W-1:0] slot_given;
    logic              grew;
    logic              overlapped;
    logic              rejected;

    // Sequence the work: accept, fit, repack on growth, hand over the result
    srp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Hold the shelf state, the glyph stores, the fit unit and the result register
    srp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_req_query    (s_axis_tuser[0]),
        .i_glyph_width  (s_axis_tdata[DIM_W-1:0]),
        .i_glyph_height (s_axis_tdata[2*DIM_W-1:DIM_W]),
        .i_glyph_slot   (s_axis_tdata[2*DIM_W+SLOT_W-1:2*DIM_W]),
        .o_pos_x        (pos_x),
        .o_pos_y        (pos_y),
        .o_side_now     (side_now),
        .o_slot_given   (slot_given),
        .o_grew         (grew),
        .o_overlapped   (overlapped),
        .o_rejected     (rejected)
    );

    // Pack the result, lowest field first, zero fill to whole bytes
    assign m_axis_tdata = {{(OUT_DATA_W - 2*POS_W - SIDE_W - SLOT_W){1'b0}},
                           slot_given, side_now, pos_y, pos_x};
    assign m_axis_tuser = {rejected, overlapped, grew};

endmodule

`default_nettype wire

// ----- src/srp_datapath.sv -----
`default_nettype none
`include "shelf_rect_packer_with_grow_defines.svh"

module srp_datapath
    import srp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    input  wire logic              i_req_query,
    input  wire logic [DIM_W-1:0]  i_glyph_width,
    input  wire logic [DIM_W-1:0]  i_glyph_height,
    input  wire logic [SLOT_W-1:0] i_glyph_slot,
    output logic [POS_W-1:0]       o_pos_x,
    output logic [POS_W-1:0]       o_pos_y,
    output logic [SIDE_W-1:0]      o_side_now,
    output logic [SLOT_W-1:0]      o_slot_given,
    output logic                   o_grew,
    output logic                   o_overlapped,
    output logic                   o_rejected
);

    typedef struct packed {
        logic              grow;
        logic              wrap;
        logic [POS_W-1:0]  ox;
        logic [POS_W-1:0]  oy;
        logic [CUR_W-1:0]  cur;
        logic [CUR_W-1:0]  top;
        logic [SIDE_W-1:0] ht;
    } t_fit;

    // One shelf placement of a (w+2) x (h+2) cell at the given side
    function automatic t_fit fit_cell(
        input logic [DIM_W-1:0]  w,
        input logic [DIM_W-1:0]  h,
        input logic [SIDE_W-1:0] side,
        input logic [CUR_W-1:0]  cur,
        input logic [CUR_W-1:0]  top,
        input logic [SIDE_W-1:0] ht
    );
        logic [SIDE_W-1:0] w2;
        logic [SIDE_W-1:0] h2;
        logic [SIDE_W-1:0] cw;
        logic [SIDE_W-1:0] ch;
        logic [CUR_W:0]    top_nx;
        t_fit              f;
        w2 = {1'b0, w} + SIDE_W'(2);
        h2 = {1'b0, h} + SIDE_W'(2);
        cw = (w2 < side) ? w2 : side;
        ch = (h2 < side) ? h2 : side;
        f.grow = 1'b0;
        f.wrap = 1'b0;
        f.cur  = cur;
        f.top  = top;
        f.ht   = ht;
        if (({1'b0, cur} + (CUR_W+1)'(cw) > (CUR_W+1)'(side)) ||
            ({1'b0, top} + (CUR_W+1)'(ch) > (CUR_W+1)'(side))) begin
            // open a new shelf below the tallest cell plus the gap
            f.cur  = '0;
            top_nx = {1'b0, top} + (CUR_W+1)'(ht) + (CUR_W+1)'(2);
            f.top  = top_nx[CUR_W-1:0];
            f.ht   = '0;
            if ({1'b0, f.top} + (CUR_W+1)'(ch) > (CUR_W+1)'(side)) begin
                if (side < MAX_SIDE) begin
                    f.grow = 1'b1;
                end else begin
                    f.top  = '0;
                    f.wrap = 1'b1;
                end
            end
        end
        f.ox  = POS_W'(f.cur + CUR_W'(1));
        f.oy  = POS_W'(f.top + CUR_W'(1));
        f.cur = f.cur + CUR_W'(cw) + CUR_W'(1);
        f.ht  = (ch > f.ht) ? ch : f.ht;
        return f;
    endfunction

    // Packing state
    logic [SIDE_W-1:0] r_side;
    logic [CUR_W-1:0]  r_cur;
    logic [CUR_W-1:0]  r_top;
    logic [SIDE_W-1:0] r_ht;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_idx;

    // Request and pending result
    logic              r_query;
    logic [DIM_W-1:0]  r_w;
    logic [DIM_W-1:0]  r_h;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_given;
    logic [POS_W-1:0]  r_px;
    logic [POS_W-1:0]  r_py;
    logic              r_grew;
    logic              r_wrap;
    logic              r_rej;

    // Glyph stores: size {h, w} and origin {y, x}
    logic [2*DIM_W-1:0] wh_mem  [GLYPHS];
    logic [2*POS_W-1:0] org_mem [GLYPHS];
    logic [2*DIM_W-1:0] r_wh_rd;
    logic [2*POS_W-1:0] r_org_rd;

    logic [DIM_W-1:0]   fit_w;
    logic [DIM_W-1:0]   fit_h;
    t_fit               fit;
    logic [SIDE_W:0]    side_dbl;
    logic [SIDE_W-1:0]  n_side;
    logic               org_we;
    logic [IDX_W-1:0]   org_addr;
    logic [POS_W-1:0]   res_x;
    logic [POS_W-1:0]   res_y;

    always_comb begin
        fit_w = i_cmd.rp_fit ? r_wh_rd[DIM_W-1:0]       : r_w;
        fit_h = i_cmd.rp_fit ? r_wh_rd[2*DIM_W-1:DIM_W] : r_h;
        fit   = fit_cell(fit_w, fit_h, r_side, r_cur, r_top, r_ht);

        side_dbl = {r_side, 1'b0};
        n_side   = (side_dbl < {1'b0, MAX_SIDE}) ? side_dbl[SIDE_W-1:0] : MAX_SIDE;

        org_we   = (i_cmd.fit_new || i_cmd.rp_fit) && !fit.grow;
        org_addr = i_cmd.fit_new ? r_count[IDX_W-1:0] : r_idx;

        o_status.in_query   = i_req_query;
        o_status.full       = (r_count == CNT_W'(GLYPHS));
        o_status.fit_grow   = fit.grow;
        o_status.idx_last   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
        o_status.count_zero = (r_count == '0);

        if (r_query) begin
            res_x = r_rej ? '0 : r_org_rd[POS_W-1:0];
            res_y = r_rej ? '0 : r_org_rd[2*POS_W-1:POS_W];
        end else begin
            res_x = r_px;
            res_y = r_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= INIT_SIDE;
            r_cur   <= '0;
            r_top   <= '0;
            r_ht    <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else if (i_cmd.fit_new || i_cmd.rp_fit) begin
            if (fit.grow) begin
                // double the side and restart the repack from the first slot
                r_side <= n_side;
                r_cur  <= '0;
                r_top  <= '0;
                r_ht   <= '0;
                r_idx  <= '0;
            end else begin
                r_cur <= fit.cur;
                r_top <= fit.top;
                r_ht  <= fit.ht;
                if (i_cmd.fit_new) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_query <= i_req_query;
            r_w     <= i_glyph_width;
            r_h     <= i_glyph_height;
            r_slot  <= i_glyph_slot;
            r_given <= i_req_query ? i_glyph_slot : '0;
            r_px    <= '0;
            r_py    <= '0;
            r_grew  <= 1'b0;
            r_wrap  <= 1'b0;
            r_rej   <= i_req_query ? (CNT_W'(i_glyph_slot) >= r_count) :
                                     (r_count == CNT_W'(GLYPHS));
        end
        if (i_cmd.fit_new) begin
            if (fit.grow) begin
                r_grew <= 1'b1;
            end else begin
                r_px    <= fit.ox;
                r_py    <= fit.oy;
                r_wrap  <= fit.wrap;
                r_given <= SLOT_W'(r_count);
            end
        end
        if (i_cmd.load_out) begin
            o_pos_x      <= res_x;
            o_pos_y      <= res_y;
            o_side_now   <= r_side;
            o_slot_given <= r_given;
            o_grew       <= r_grew;
            o_overlapped <= r_wrap;
            o_rejected   <= r_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fit_new && !fit.grow) begin
            wh_mem[r_count[IDX_W-1:0]] <= {r_h, r_w};
        end
        if (org_we) begin
            org_mem[org_addr] <= {fit.oy, fit.ox};
        end
        if (i_cmd.rp_read) begin
            r_wh_rd <= wh_mem[r_idx];
        end
        if (i_cmd.q_read) begin
            r_org_rd <= org_mem[r_slot[IDX_W-1:0]];
        end
    end

    `SRP_ASSERT_IMP(a_side_range, 1'b1, (r_side >= INIT_SIDE && r_side <= MAX_SIDE), "atlas side out of range")
    `SRP_ASSERT_NXT(a_count_step, (i_cmd.fit_new && !fit.grow), (r_count == $past(r_count) + CNT_W'(1)), "glyph count did not advance on placement")
    `SRP_ASSERT_IMP(a_count_bound, 1'b1, (r_count <= CNT_W'(GLYPHS)), "glyph count beyond store depth")

endmodule

`default_nettype wire

// ----- src/srp_ctrl.sv -----
`default_nettype none
`include "shelf_rect_packer_with_grow_defines.svh"

module srp_ctrl
    import srp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUERY,
        S_FIT,
        S_RP_RD,
        S_RP_FIT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.in_query) begin
                        n_state = S_QUERY;
                    end else if (i_status.full) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FIT;
                    end
                end
            end
            S_QUERY: begin
                o_cmd.q_read = 1'b1;
                n_state      = S_DONE;
            end
            S_FIT: begin
                o_cmd.fit_new = 1'b1;
                if (i_status.fit_grow) begin
                    n_state = i_status.count_zero ? S_FIT : S_RP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RP_RD: begin
                o_cmd.rp_read = 1'b1;
                n_state       = S_RP_FIT;
            end
            S_RP_FIT: begin
                o_cmd.rp_fit = 1'b1;
                if (i_status.fit_grow) begin
                    n_state = S_RP_RD;
                end else if (i_status.idx_last) begin
                    n_state = S_FIT;
                end else begin
                    n_state = S_RP_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `SRP_ASSERT_NXT(a_done_hold, (r_state == S_DONE && r_out_valid && !i_out_ready), (r_state == S_DONE), "result loaded over an untaken one")
    `SRP_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(o_cmd), "more than one datapath command")
    `SRP_ASSERT_NXT(a_query_path, (r_state == S_IDLE && i_in_valid && i_status.in_query), (r_state == S_QUERY), "query did not go to the store read")

endmodule

`default_nettype wire
